[src/psfd_pkg.sv]
// Shared types and constants for the photosensitive flash detector.
package psfd_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_EOF   = 2'd2;

   localparam logic [2:0] CSR_MIN_AREA   = 3'd0;
   localparam logic [2:0] CSR_WINDOW     = 3'd1;
   localparam logic [2:0] CSR_LIMIT      = 3'd2;
   localparam logic [2:0] CSR_LUMA_STEP  = 3'd3;
   localparam logic [2:0] CSR_LUMA_BRIGHT = 3'd4;
   localparam logic [2:0] CSR_RED_LIMIT  = 3'd5;
   localparam logic [2:0] CSR_CHROMA_SQ  = 3'd6;

   localparam int COUNT_W = 22;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Input beat: op, lut_index, lut_value, red, green, blue (lowest first)
   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [15:0] lut_value;
      logic [7:0]  lut_index;
      logic [1:0]  op;
   } req_type;

   typedef struct packed {
      logic       has_red;
      logic       has_flash;
      logic [6:0] red_marked_in_window;
      logic [6:0] luma_marked_in_window;
      logic       red_frame_marked;
      logic       luma_frame_marked;
   } rsp_type;

   // Per-pixel history word
   typedef struct packed {
      logic [3:0]  flags;
      logic [15:0] cv;
      logic [15:0] cu;
      logic [15:0] rr;
      logic [15:0] lum;
   } hist_type;

endpackage

[src/psfd_divider.sv]
// Restoring divider: 16-bit saturated quotient of num*2^16 / den, one bit per cycle.
module psfd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [37:0] num,
   input  logic [37:0] den,
   output logic        done,
   output logic [15:0] quot
);
   import psfd_pkg::*;

   // quotient >= 2^16 exactly when num >= den; else 16 steps produce it
   logic [38:0] rem_ff, rem_in;
   logic [37:0] den_ff;
   logic [15:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [38:0] trial;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[37:0], 1'b0};
      if (start) begin
         rem_in = {1'b0, num};
         q_in = 16'd0;
         cnt_in = 5'd0;
         if (den == 38'd0) begin
            done_in = 1'b1;
         end else if (num >= den) begin
            q_in = 16'hFFFF;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

[src/photosensitive_flash_detector_unit.sv]
// Top level of the photosensitive flash detector.
//
//  Channel   Dir  Beat contents
//  req_      in   tuser: op; tdata: lut_index, lut_value, red, green, blue
//  rsp_      out  tdata: frame marks, window totals, sticky flags
//  csr_      in   write enable, index, data
//
//  End of frame checks the window, reads and drops each surplus oldest entry,
//  then pushes its result. A pixel runs through lookup, mac, sum, three
//  divisions (red ratio, u', v') on one shared divider, distance and write
//  back.
//  After reset a clearing pass walks the pixel history memory, one entry a
//  cycle, with req_tready low.
//  A finished result waits in the output register; loads and pixels keep
//  flowing, and an end of frame holds in its last cycle until it has gone.
module photosensitive_flash_detector_unit #(
   parameter int FRAME_WIDTH  = 1920,
   parameter int FRAME_HEIGHT = 1080,
   parameter int LUT_ENTRIES  = 256,
   parameter int WINDOW_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op[1:0]
   input  logic [47:0] req_tdata,   // lut_index[7:0] lut_value[23:8]
                                    // red[31:24] green[39:32] blue[47:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // luma_frame_marked[0] red_frame_marked[1]
                                    // luma_marked_in_window[8:2]
                                    // red_marked_in_window[15:9]
                                    // has_flash[16] has_red[17]
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_data
);
   import psfd_pkg::*;

   localparam int PIX    = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int PIX_W  = $clog2(PIX);
   localparam int WIN_W  = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W  = CNT_W + 5;
   localparam int LUT_W  = $clog2(LUT_ENTRIES);

   // sequencer codes
   localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_LUT = 4'd2,
                          ST_MAC = 4'd3, ST_SUM = 4'd4, ST_DIVR = 4'd5,
                          ST_DIVU = 4'd6, ST_DIVV = 4'd7, ST_CMP = 4'd8,
                          ST_EOF_DROP = 4'd9, ST_EOF_RD = 4'd10,
                          ST_EOF_DONE = 4'd11, ST_DIST = 4'd12,
                          ST_EOF_PUSH = 4'd13;

   req_type req;
   assign req = req_type'({req_tdata, req_tuser});

   // configuration
   logic [20:0] min_area_ff;
   logic [6:0]  window_frames_ff;
   logic [4:0]  flash_limit_ff;
   logic [15:0] luma_step_ff, luma_bright_ff, red_limit_ff, chroma_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= 21'd21824;
         window_frames_ff <= 7'd30;
         flash_limit_ff <= 5'd3;
         luma_step_ff <= 16'd6554;
         luma_bright_ff <= 16'd52429;
         red_limit_ff <= 16'd52429;
         chroma_sq_ff <= 16'd2621;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_MIN_AREA:    min_area_ff <= csr_data;
            CSR_WINDOW:      window_frames_ff <= csr_data[6:0];
            CSR_LIMIT:       flash_limit_ff <= csr_data[4:0];
            CSR_LUMA_STEP:   luma_step_ff <= csr_data[15:0];
            CSR_LUMA_BRIGHT: luma_bright_ff <= csr_data[15:0];
            CSR_RED_LIMIT:   red_limit_ff <= csr_data[15:0];
            CSR_CHROMA_SQ:   chroma_sq_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // memories
   logic [15:0]    gamma_mem [LUT_ENTRIES];
   hist_type       hist_mem  [PIX];
   logic [1:0]     win_mem   [WINDOW_DEPTH];

   logic [3:0]  state_ff, state_in;
   logic [PIX_W-1:0] pos_ff, pos_in;
   logic [1:0]  lut_ph_ff, lut_ph_in;   // which channel is being looked up
   logic [15:0] lin_r_ff, lin_g_ff, lin_b_ff;
   logic [15:0] gamma_rd_ff;
   hist_type    hist_rd_ff;
   logic [1:0]  win_rd_ff;

   // pixel datapath registers
   logic [7:0]  code_r_ff, code_g_ff, code_b_ff;
   logic [1:0]  mac_ph_ff, mac_ph_in;
   logic [33:0] lum_acc_ff, x_ff, y_ff, z_ff;
   logic [37:0] d_ff;
   logic [17:0] rgb_sum_ff;
   logic [15:0] lum_ff, rr_ff, cu_ff, cv_ff;
   logic [33:0] dist_ff;
   logic        div_started_ff, div_started_in;

   logic [COUNT_W-1:0] lrise_ff, lfall_ff, rrise_ff, rfall_ff;
   logic [WIN_W-1:0]   head_ff;
   logic [CNT_W-1:0]   fill_ff, ltot_ff, rtot_ff;
   logic               flash_ff, redseen_ff;
   logic               lm_ff, rm_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // divider
   logic        div_start, div_done;
   logic [37:0] div_num, div_den;
   logic [15:0] div_q;

   psfd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
   );

   assign div_start = (state_ff == ST_DIVR || state_ff == ST_DIVU ||
                       state_ff == ST_DIVV) && !div_started_ff;
   always_comb begin
      unique case (state_ff)
         ST_DIVU: begin div_num = {2'b00, x_ff, 2'b00}; div_den = d_ff; end
         ST_DIVV: begin div_num = {1'b0, y_ff, 3'b000} + {4'd0, y_ff};
                        div_den = d_ff; end
         default: begin div_num = {22'd0, lin_r_ff}; div_den = {20'd0, rgb_sum_ff}; end
      endcase
   end

   // window length clamp
   logic [CNT_W-1:0] win_len;
   always_comb begin
      if (window_frames_ff == 7'd0) win_len = CNT_W'(1);
      else if ({2'b0, window_frames_ff} > 9'(WINDOW_DEPTH)) win_len = CNT_W'(WINDOW_DEPTH);
      else win_len = CNT_W'(window_frames_ff);
   end
   // oldest entry, wrapping at the window depth
   logic [WIN_W-1:0] oldest;
   assign oldest = (CNT_W'(head_ff) >= fill_ff) ? WIN_W'(CNT_W'(head_ff) - fill_ff) :
                   WIN_W'(CNT_W'(head_ff) + CNT_W'(WINDOW_DEPTH) - fill_ff);

   // gamma read address follows the lookup phase
   logic [LUT_W-1:0] gamma_addr;
   always_comb begin
      unique case (lut_ph_ff)
         2'd0: gamma_addr = code_r_ff;
         2'd1: gamma_addr = code_g_ff;
         default: gamma_addr = code_b_ff;
      endcase
   end

   // coefficient mac: one channel per cycle
   logic [15:0] mac_in;
   logic [15:0] k_l, k_x, k_y, k_z;
   always_comb begin
      unique case (mac_ph_ff)
         2'd0: begin mac_in = lin_r_ff; k_l = 16'd13933; k_x = 16'd27031;
                     k_y = 16'd13938; k_z = 16'd1267; end
         2'd1: begin mac_in = lin_g_ff; k_l = 16'd46871; k_x = 16'd23434;
                     k_y = 16'd46868; k_z = 16'd7811; end
         default: begin mac_in = lin_b_ff; k_l = 16'd4732; k_x = 16'd11825;
                     k_y = 16'd4730; k_z = 16'd62279; end
      endcase
   end

   // trend logic
   hist_type   new_hist;
   logic       l_inc_rise, l_inc_fall, r_inc_rise, r_inc_fall;
   logic [15:0] ldiff;
   logic       lharm, rharm;
   always_comb begin
      hist_type h;
      h = hist_rd_ff;
      new_hist.lum = lum_ff;
      new_hist.rr = rr_ff;
      new_hist.cu = cu_ff;
      new_hist.cv = cv_ff;
      new_hist.flags = h.flags;
      ldiff = (h.lum > lum_ff) ? h.lum - lum_ff : lum_ff - h.lum;
      lharm = ldiff > luma_step_ff && (h.lum < luma_bright_ff || lum_ff < luma_bright_ff);
      rharm = (h.rr >= red_limit_ff || rr_ff >= red_limit_ff) &&
              dist_ff > {2'b0, chroma_sq_ff, 16'd0};
      l_inc_rise = 1'b0; l_inc_fall = 1'b0; r_inc_rise = 1'b0; r_inc_fall = 1'b0;
      if (lharm) begin
         new_hist.flags[0] = h.lum < lum_ff;
         new_hist.flags[1] = h.lum > lum_ff;
         l_inc_fall = h.flags[0] && new_hist.flags[1];
         l_inc_rise = h.flags[1] && new_hist.flags[0];
      end
      if (rharm) begin
         new_hist.flags[2] = h.rr < rr_ff;
         new_hist.flags[3] = h.rr > rr_ff;
         r_inc_fall = h.flags[2] && new_hist.flags[3];
         r_inc_rise = h.flags[3] && new_hist.flags[2];
      end
   end

   // squared chroma distance, one product term per cycle
   logic [16:0] dsel;
   logic [15:0] du, dv;
   assign du = (hist_rd_ff.cu > cu_ff) ? hist_rd_ff.cu - cu_ff : cu_ff - hist_rd_ff.cu;
   assign dv = (hist_rd_ff.cv > cv_ff) ? hist_rd_ff.cv - cv_ff : cv_ff - hist_rd_ff.cv;
   assign dsel = {1'b0, div_started_ff ? dv : du};

   assign req_tready = (state_ff == ST_IDLE);
   logic accept;
   assign accept = req_tvalid && req_tready;

   // end of frame completes once the output register is free or freeing
   logic push_go;
   assign push_go = (state_ff == ST_EOF_PUSH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      lut_ph_in = lut_ph_ff;
      mac_ph_in = mac_ph_ff;
      div_started_in = div_started_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            pos_in = pos_ff + PIX_W'(1);
            if (pos_ff == PIX_W'(PIX - 1)) begin
               pos_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: if (accept) begin
            priority case (req.op)
               OP_LOAD:  state_in = ST_IDLE;
               OP_PIXEL: begin state_in = ST_LUT; lut_ph_in = 2'd0; end
               OP_EOF:   state_in = ST_EOF_DROP;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_LUT: begin
            lut_ph_in = lut_ph_ff + 2'd1;
            if (lut_ph_ff == 2'd3) begin state_in = ST_MAC; mac_ph_in = 2'd0; end
         end
         ST_MAC: begin
            mac_ph_in = mac_ph_ff + 2'd1;
            if (mac_ph_ff == 2'd2) state_in = ST_SUM;
         end
         ST_SUM: begin state_in = ST_DIVR; div_started_in = 1'b0; end
         ST_DIVR: begin
            div_started_in = 1'b1;
            if (div_done && div_started_ff) begin state_in = ST_DIVU; div_started_in = 1'b0; end
         end
         ST_DIVU: begin
            div_started_in = 1'b1;
            if (div_done && div_started_ff) begin state_in = ST_DIVV; div_started_in = 1'b0; end
         end
         ST_DIVV: begin
            div_started_in = 1'b1;
            if (div_done && div_started_ff) begin state_in = ST_DIST; div_started_in = 1'b0; end
         end
         ST_DIST: begin
            div_started_in = 1'b1;
            if (div_started_ff) state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_IDLE;
            pos_in = (pos_ff == PIX_W'(PIX - 1)) ? '0 : pos_ff + PIX_W'(1);
         end
         ST_EOF_DROP: state_in = (fill_ff >= win_len) ? ST_EOF_RD : ST_EOF_PUSH;
         ST_EOF_RD:   state_in = ST_EOF_DONE;
         ST_EOF_DONE: state_in = ST_EOF_DROP;
         ST_EOF_PUSH: if (push_go) begin state_in = ST_IDLE; pos_in = '0; end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pos_ff <= '0;
         lut_ph_ff <= 2'd0;
         mac_ph_ff <= 2'd0;
         div_started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         lut_ph_ff <= lut_ph_in;
         mac_ph_ff <= mac_ph_in;
         div_started_ff <= div_started_in;
      end
   end

   // gamma table: write on load, read while looking up
   always_ff @(posedge clock) begin
      if (accept && req.op == OP_LOAD) gamma_mem[req.lut_index] <= req.lut_value;
      gamma_rd_ff <= gamma_mem[gamma_addr];
   end

   // pixel history: cleared after reset, read at lookup, written at compare
   hist_type clear_word;
   always_comb begin
      clear_word = '0;
      clear_word.flags = 4'b1010;
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) hist_mem[pos_ff] <= clear_word;
      else if (state_ff == ST_CMP) hist_mem[pos_ff] <= new_hist;
      hist_rd_ff <= hist_mem[pos_ff];
   end

   // window marks
   always_ff @(posedge clock) begin
      if (push_go) win_mem[head_ff] <= {rm_ff, lm_ff};
      win_rd_ff <= win_mem[oldest];
   end

   // pixel arithmetic
   always_ff @(posedge clock) begin
      if (accept) begin
         code_r_ff <= req.red;
         code_g_ff <= req.green;
         code_b_ff <= req.blue;
      end
      if (state_ff == ST_LUT) begin
         unique case (lut_ph_ff)
            2'd1: lin_r_ff <= gamma_rd_ff;
            2'd2: lin_g_ff <= gamma_rd_ff;
            2'd3: lin_b_ff <= gamma_rd_ff;
            default: ;
         endcase
      end
      if (state_ff == ST_MAC) begin
         if (mac_ph_ff == 2'd0) begin
            lum_acc_ff <= 34'(mac_in * k_l) + 34'd32768;
            x_ff <= 34'(mac_in * k_x);
            y_ff <= 34'(mac_in * k_y);
            z_ff <= 34'(mac_in * k_z);
         end else begin
            lum_acc_ff <= lum_acc_ff + 34'(mac_in * k_l);
            x_ff <= x_ff + 34'(mac_in * k_x);
            y_ff <= y_ff + 34'(mac_in * k_y);
            z_ff <= z_ff + 34'(mac_in * k_z);
         end
      end
      if (state_ff == ST_SUM) begin
         lum_ff <= lum_acc_ff[31:16];
         rgb_sum_ff <= 18'(lin_r_ff) + 18'(lin_g_ff) + 18'(lin_b_ff);
         d_ff <= 38'(x_ff) + (38'(y_ff) << 4) - 38'(y_ff) + (38'(z_ff) << 1) + 38'(z_ff);
      end
      if (div_done && div_started_ff) begin
         unique case (state_ff)
            ST_DIVR: rr_ff <= div_q;
            ST_DIVU: cu_ff <= div_q;
            ST_DIVV: cv_ff <= div_q;
            default: ;
         endcase
      end
      if (state_ff == ST_DIST) begin
         if (!div_started_ff) dist_ff <= 34'(dsel * dsel);
         else dist_ff <= dist_ff + 34'(dsel * dsel);
      end
   end

   // counters, window and result
   logic [CNT_W-1:0] ltot_new, rtot_new;
   logic             lflag_new, rflag_new;
   assign ltot_new = ltot_ff + CNT_W'(lm_ff);
   assign rtot_new = rtot_ff + CNT_W'(rm_ff);
   assign lflag_new = CMP_W'(ltot_new >> 1) > CMP_W'(flash_limit_ff);
   assign rflag_new = CMP_W'(rtot_new >> 1) > CMP_W'(flash_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lrise_ff <= '0; lfall_ff <= '0; rrise_ff <= '0; rfall_ff <= '0;
         head_ff <= '0; fill_ff <= '0; ltot_ff <= '0; rtot_ff <= '0;
         flash_ff <= 1'b0; redseen_ff <= 1'b0;
         lm_ff <= 1'b0; rm_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_CMP) begin
            if (l_inc_rise && lrise_ff != COUNT_MAX) lrise_ff <= lrise_ff + COUNT_W'(1);
            if (l_inc_fall && lfall_ff != COUNT_MAX) lfall_ff <= lfall_ff + COUNT_W'(1);
            if (r_inc_rise && rrise_ff != COUNT_MAX) rrise_ff <= rrise_ff + COUNT_W'(1);
            if (r_inc_fall && rfall_ff != COUNT_MAX) rfall_ff <= rfall_ff + COUNT_W'(1);
         end
         if (accept && req.op == OP_EOF) begin
            lm_ff <= lrise_ff > 22'(min_area_ff) || lfall_ff > 22'(min_area_ff);
            rm_ff <= rrise_ff > 22'(min_area_ff) || rfall_ff > 22'(min_area_ff);
         end
         if (state_ff == ST_EOF_DONE) begin
            ltot_ff <= ltot_ff - CNT_W'(win_rd_ff[0]);
            rtot_ff <= rtot_ff - CNT_W'(win_rd_ff[1]);
            fill_ff <= fill_ff - CNT_W'(1);
         end
         if (push_go) begin
            head_ff <= (head_ff == WIN_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + WIN_W'(1);
            fill_ff <= fill_ff + CNT_W'(1);
            ltot_ff <= ltot_new;
            rtot_ff <= rtot_new;
            if (lflag_new) flash_ff <= 1'b1;
            if (rflag_new) redseen_ff <= 1'b1;
            lrise_ff <= '0; lfall_ff <= '0; rrise_ff <= '0; rfall_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         rsp_ff.luma_frame_marked <= lm_ff;
         rsp_ff.red_frame_marked <= rm_ff;
         rsp_ff.luma_marked_in_window <= 7'(ltot_new);
         rsp_ff.red_marked_in_window <= 7'(rtot_new);
         rsp_ff.has_flash <= flash_ff || lflag_new;
         rsp_ff.has_red <= redseen_ff || rflag_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_ff};

`ifndef SYNTHESIS
   a_win_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_DEPTH)) else $error("window fill overrun");
   a_tot_bound: assert property (@(posedge clock) disable iff (reset)
      ltot_ff <= fill_ff && rtot_ff <= fill_ff) else $error("window total above fill");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("waiting result dropped or changed");
`endif
endmodule

[sim/tb.sv]
// Self-checking testbench for the photosensitive flash detector unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psfd_pkg::*;

   // Small frames keep the post-reset clearing pass and the wrap case short.
   localparam int FW = 16;
   localparam int FH = 16;
   localparam int PIXELS = FW * FH;
   localparam int WIN_DEPTH = 64;
   localparam int STALL_LIMIT = 5000;   // cycles with no beat on either side
   localparam int SETTLE = 80;          // wait after the queue empties for a pixel in flight
   localparam int PHASE_ITEMS = 110;

   localparam logic [1:0] OP_SPARE = 2'd3;   // ignored by the block

   localparam logic [3:0] TF_LRISE = 4'b0001;
   localparam logic [3:0] TF_LFALL = 4'b0010;
   localparam logic [3:0] TF_RRISE = 4'b0100;
   localparam logic [3:0] TF_RFALL = 4'b1000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // op
   logic [47:0] req_tdata;   // lut_index, lut_value, red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // frame marks, window totals, has_flash, has_red
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [20:0] csr_data;

   photosensitive_flash_detector_unit #(
      .FRAME_WIDTH(FW), .FRAME_HEIGHT(FH), .WINDOW_DEPTH(WIN_DEPTH)
   ) DUT (.*);

   // ---- stimulus and checking stores ----
   req_type feed_q[$];       // beats waiting for the driver
   rsp_type frame_verdicts[$];
   int unsigned failures;
   int unsigned quiet_cycles;
   logic req_taken;          // beat accepted at the last rising edge
   logic no_idle;            // stretch with both sides always ready

   // ---- shadow state of the detector ----
   logic [15:0] gamma_lut [256];
   logic [15:0] hist_luma [PIXELS];
   logic [15:0] hist_rr [PIXELS];
   logic [15:0] hist_u [PIXELS];
   logic [15:0] hist_v [PIXELS];
   logic [3:0]  hist_trend [PIXELS];
   int unsigned pix_pos;
   int unsigned luma_rises, luma_falls, red_rises, red_falls;
   logic [1:0]  win_marks [WIN_DEPTH];
   int unsigned win_head, win_fill, luma_total, red_total;
   logic        flash_flag, red_flag;
   int unsigned area_min, win_len, limit_cfg, step_cfg, bright_cfg, red_cfg, chroma_cfg;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] sat_quot(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return 16'd0;
      q = num / den;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic int unsigned bump(int unsigned c);
      return (c < COUNT_MAX) ? c + 1 : c;
   endfunction

   task automatic shade_pixel(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc);
      longint unsigned r, g, b, x, y, z, d, dsq;
      longint du, dv;
      logic [15:0] lum, rr, cu, cv, pl, pr;
      logic [3:0] fl, nf;
      int unsigned diff;
      r = gamma_lut[rc];
      g = gamma_lut[gc];
      b = gamma_lut[bc];
      lum = 16'((13933 * r + 46871 * g + 4732 * b + 32768) >> 16);
      rr = sat_quot(r << 16, r + g + b);
      x = 27031 * r + 23434 * g + 11825 * b;
      y = 13938 * r + 46868 * g + 4730 * b;
      z = 1267 * r + 7811 * g + 62279 * b;
      d = x + 15 * y + 3 * z;
      cu = sat_quot((4 * x) << 16, d);
      cv = sat_quot((9 * y) << 16, d);
      pl = hist_luma[pix_pos];
      pr = hist_rr[pix_pos];
      fl = hist_trend[pix_pos];
      nf = fl;
      diff = (pl > lum) ? pl - lum : lum - pl;
      if (diff > step_cfg && (pl < bright_cfg || lum < bright_cfg)) begin
         nf &= ~(TF_LRISE | TF_LFALL);
         if (pl < lum) nf |= TF_LRISE;
         if (pl > lum) nf |= TF_LFALL;
         if ((fl & TF_LRISE) && (nf & TF_LFALL)) luma_falls = bump(luma_falls);
         if ((fl & TF_LFALL) && (nf & TF_LRISE)) luma_rises = bump(luma_rises);
      end
      du = longint'(hist_u[pix_pos]) - longint'(cu);
      dv = longint'(hist_v[pix_pos]) - longint'(cv);
      dsq = longint'(du * du) + longint'(dv * dv);
      if ((pr >= red_cfg || rr >= red_cfg) && dsq > (longint'(chroma_cfg) << 16)) begin
         nf &= ~(TF_RRISE | TF_RFALL);
         if (pr < rr) nf |= TF_RRISE;
         if (pr > rr) nf |= TF_RFALL;
         if ((fl & TF_RRISE) && (nf & TF_RFALL)) red_falls = bump(red_falls);
         if ((fl & TF_RFALL) && (nf & TF_RRISE)) red_rises = bump(red_rises);
      end
      hist_luma[pix_pos] = lum;
      hist_rr[pix_pos] = rr;
      hist_u[pix_pos] = cu;
      hist_v[pix_pos] = cv;
      hist_trend[pix_pos] = nf;
      pix_pos = (pix_pos + 1 >= PIXELS) ? 0 : pix_pos + 1;
   endtask

   task automatic close_frame();
      logic lm, rm;
      int unsigned w, oldest;
      rsp_type v;
      lm = luma_rises > area_min || luma_falls > area_min;
      rm = red_rises > area_min || red_falls > area_min;
      w = (win_len < 1) ? 1 : (win_len > WIN_DEPTH) ? WIN_DEPTH : win_len;
      // shrinking the window drops every surplus oldest frame at once
      while (win_fill >= w) begin
         oldest = (win_head + WIN_DEPTH - win_fill) % WIN_DEPTH;
         if (win_marks[oldest][0]) luma_total--;
         if (win_marks[oldest][1]) red_total--;
         win_fill--;
      end
      win_marks[win_head] = {rm, lm};
      win_head = (win_head + 1) % WIN_DEPTH;
      win_fill++;
      if (lm) luma_total++;
      if (rm) red_total++;
      if (luma_total / 2 > limit_cfg) flash_flag = 1'b1;
      if (red_total / 2 > limit_cfg) red_flag = 1'b1;
      luma_rises = 0; luma_falls = 0; red_rises = 0; red_falls = 0;
      pix_pos = 0;
      v.luma_frame_marked = lm;
      v.red_frame_marked = rm;
      v.luma_marked_in_window = 7'(luma_total);
      v.red_marked_in_window = 7'(red_total);
      v.has_flash = flash_flag;
      v.has_red = red_flag;
      frame_verdicts = {frame_verdicts, v};
   endtask

   task automatic predict_beat(req_type b);
      case (b.op)
         OP_LOAD:  gamma_lut[b.lut_index] = b.lut_value;
         OP_PIXEL: shade_pixel(b.red, b.green, b.blue);
         OP_EOF:   close_frame();
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      failures++;
   endtask

   // ---- monitor, predictor hook and watchdog ----
   always @(posedge clock) begin
      rsp_type got, want;
      req_taken = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            quiet_cycles = 0;
            predict_beat(req_type'({req_tdata, req_tuser}));
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            got = rsp_type'(rsp_tdata[17:0]);
            if (frame_verdicts.size() == 0) begin
               report_mismatch("unexpected beat", int'(rsp_tdata), 0);
            end else begin
               want = frame_verdicts.pop_front();
               if (got.luma_frame_marked !== want.luma_frame_marked)
                  report_mismatch("luma_frame_marked", got.luma_frame_marked,
                                  want.luma_frame_marked);
               if (got.red_frame_marked !== want.red_frame_marked)
                  report_mismatch("red_frame_marked", got.red_frame_marked,
                                  want.red_frame_marked);
               if (got.luma_marked_in_window !== want.luma_marked_in_window)
                  report_mismatch("luma_marked_in_window", got.luma_marked_in_window,
                                  want.luma_marked_in_window);
               if (got.red_marked_in_window !== want.red_marked_in_window)
                  report_mismatch("red_marked_in_window", got.red_marked_in_window,
                                  want.red_marked_in_window);
               if (got.has_flash !== want.has_flash)
                  report_mismatch("has_flash", got.has_flash, want.has_flash);
               if (got.has_red !== want.has_red)
                  report_mismatch("has_red", got.has_red, want.has_red);
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---- driver: new beat or idle on the falling edge ----
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 19);
         if (!req_tvalid || req_taken) begin
            if (feed_q.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
               {req_tdata, req_tuser} <= feed_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic req_type mk_beat(logic [1:0] op, logic [7:0] idx, logic [15:0] val,
                                       logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type t;
      t.op = op; t.lut_index = idx; t.lut_value = val;
      t.red = r; t.green = g; t.blue = b;
      return t;
   endfunction

   task automatic queue_beat(req_type t);
      feed_q = {feed_q, t};
   endtask

   task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      queue_beat(mk_beat(OP_PIXEL, 8'($urandom), 16'($urandom), r, g, b));
   endtask

   task automatic push_eof();
      queue_beat(mk_beat(OP_EOF, 8'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom)));
   endtask

   // One frame alternating dark and bright, plain or red, with some noise.
   task automatic push_frame(int unsigned fno, inout int unsigned issued);
      int unsigned n, k;
      logic lit, redish;
      n = ($urandom_range(19) == 0) ? PIXELS + 40 : $urandom_range(40, 8);
      lit = fno[0];
      redish = fno[1];
      for (k = 0; k < n; k++) begin
         if ($urandom_range(49) == 0) begin
            queue_beat(mk_beat(OP_LOAD, 8'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom)));
            issued++;
         end else if ($urandom_range(49) == 0) begin
            queue_beat(mk_beat(OP_SPARE, 8'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom)));
         end
         if ($urandom_range(99) < 20)
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         else if (redish)
            push_pixel(lit ? 8'($urandom_range(255, 250)) : 8'($urandom_range(63, 60)),
                       lit ? 8'($urandom_range(3)) : 8'd60,
                       lit ? 8'($urandom_range(3)) : 8'd60);
         else
            push_pixel(lit ? 8'($urandom_range(255, 240)) : 8'($urandom_range(15)),
                       lit ? 8'($urandom_range(255, 240)) : 8'($urandom_range(15)),
                       lit ? 8'($urandom_range(255, 240)) : 8'($urandom_range(15)));
      end
      push_eof();
      issued += n + 1;
   endtask

   // Wait for the block to go idle, then give a pixel in flight time to finish.
   task automatic drain();
      while (feed_q.size() > 0 || req_tvalid || frame_verdicts.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_data <= 21'(val);
      case (idx)
         CSR_MIN_AREA:    area_min = val & 32'h1FFFFF;
         CSR_WINDOW:      win_len = val & 32'h7F;
         CSR_LIMIT:       limit_cfg = val & 32'h1F;
         CSR_LUMA_STEP:   step_cfg = val & 32'hFFFF;
         CSR_LUMA_BRIGHT: bright_cfg = val & 32'hFFFF;
         CSR_RED_LIMIT:   red_cfg = val & 32'hFFFF;
         CSR_CHROMA_SQ:   chroma_cfg = val & 32'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // min_area, window, limit, luma step, bright level, red limit, chroma step
   int unsigned settings [6][7] = '{
      '{2, 4, 0, 6554, 52429, 52429, 2621},
      '{0, 1, 31, 0, 65535, 0, 0},
      '{5, 64, 1, 20000, 30000, 40000, 500},
      '{2073600, 0, 2, 65535, 0, 65535, 65535},
      '{1, 100, 3, 3000, 52429, 52429, 2621},
      '{3, 10, 0, 6554, 60000, 30000, 100}
   };

   initial begin
      int unsigned issued, fno;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wen = 1'b0;
      csr_index = CSR_MIN_AREA;
      csr_data = '0;
      no_idle = 1'b0;
      req_taken = 1'b0;
      failures = 0;
      quiet_cycles = 0;
      area_min = 21824; win_len = 30; limit_cfg = 3; step_cfg = 6554;
      bright_cfg = 52429; red_cfg = 52429; chroma_cfg = 2621;
      foreach (gamma_lut[i]) gamma_lut[i] = '0;
      for (int p = 0; p < PIXELS; p++) begin
         hist_luma[p] = '0; hist_rr[p] = '0; hist_u[p] = '0; hist_v[p] = '0;
         hist_trend[p] = TF_LFALL | TF_RFALL;
      end
      pix_pos = 0;
      luma_rises = 0; luma_falls = 0; red_rises = 0; red_falls = 0;
      foreach (win_marks[i]) win_marks[i] = '0;
      win_head = 0; win_fill = 0; luma_total = 0; red_total = 0;
      flash_flag = 1'b0; red_flag = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      fno = 0;
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < 7; r++) write_reg(3'(r), settings[ph][r]);
         issued = 0;
         no_idle = (ph == 2);
         if (ph == 0) begin
            // full gamma table first, so no pixel reads an unwritten entry
            for (int i = 0; i < 256; i++)
               queue_beat(mk_beat(OP_LOAD, 8'(i), 16'(i * 257), 8'd0, 8'd0, 8'd0));
            // extremes, primaries, spare op, empty frame
            push_pixel(8'd0, 8'd0, 8'd0);
            push_pixel(8'd255, 8'd255, 8'd255);
            push_pixel(8'd255, 8'd0, 8'd0);
            push_pixel(8'd0, 8'd255, 8'd0);
            push_pixel(8'd0, 8'd0, 8'd255);
            push_eof();
            queue_beat(mk_beat(OP_SPARE, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
            push_pixel(8'd255, 8'd255, 8'd255);
            push_pixel(8'd0, 8'd0, 8'd0);
            push_pixel(8'd0, 8'd0, 8'd0);
            push_pixel(8'd255, 8'd0, 8'd0);
            push_eof();
            push_eof();
            issued = 12;
         end
         while (issued < PHASE_ITEMS) begin
            push_frame(fno, issued);
            fno++;
         end
         drain();
      end

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[photosensitive_flash_detector_unit.f]
src/psfd_pkg.sv
src/psfd_divider.sv
src/photosensitive_flash_detector_unit.sv
sim/tb.sv
